FILE: design/magnetometer_heading_unit_assert.svh
// Assertion macros for the magnetometer heading unit.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef MAGNETOMETER_HEADING_UNIT_ASSERT_SVH
`define MAGNETOMETER_HEADING_UNIT_ASSERT_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define MHU_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define MHU_CHECK_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
	else $error(msg);
`else
`define MHU_CHECK(lbl, cond, msg)
`define MHU_CHECK_NEXT(lbl, trig, cond, msg)
`endif
`endif

FILE: design/mhu_pkg.sv
// Shared constants, types and the arctangent table of the heading unit.
// Depends on nothing; the interface, stage and top design files use it.
`default_nettype none
package mhu_pkg;
	localparam int BYTE_W = 8;
	localparam int FIELD_W = 16;
	localparam int HEADING_W = 15;
	localparam int DRDY_BIT = 0;

	// CORDIC vector holds the counts scaled by 2^24 with headroom for gain.
	localparam int INPUT_SHIFT = 24;
	localparam int VEC_W = 44;
	// Angle accumulator in degrees times 2^20.
	localparam int ANG_FRAC = 20;
	localparam int ANG_W = 32;

	localparam int TABLE_LEN = 24;
	localparam int STEP_IDX_W = 5;
	localparam int CORDIC_STEPS = 16;
	localparam int NUM_CELLS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	localparam int HEADING_FRAC_BITS = 6;
	localparam int FRAC_EFF = (HEADING_FRAC_BITS > 19) ? 19 : HEADING_FRAC_BITS;
	localparam int ROUND_SH = ANG_FRAC - FRAC_EFF;
	localparam int HEADING_FULL = 360 * (1 << FRAC_EFF);

	localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(90 * (1 << ANG_FRAC));
	localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360 * (1 << ANG_FRAC));
	localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(1 << (ROUND_SH - 1));
	localparam logic signed [ANG_W-1:0] HEADING_FULL_A = ANG_W'(HEADING_FULL);

	// atan(2^-i) in degrees times 2^20, rounded to nearest.
	localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
		32'sd3750058, 32'sd1876857, 32'sd938658, 32'sd469357,
		32'sd234682, 32'sd117342, 32'sd58671, 32'sd29335,
		32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115,
		32'sd57, 32'sd29, 32'sd14, 32'sd7
	};

	// One item in flight through the rotation chain.
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic zero_vec;
		logic signed [FIELD_W-1:0] x_field;
		logic signed [FIELD_W-1:0] y_field;
		logic signed [FIELD_W-1:0] z_field;
	} cordic_vec_t;

	function automatic logic signed [ANG_W-1:0] atan_of(input logic [STEP_IDX_W-1:0] idx);
		return ATAN_TAB[idx];
	endfunction
endpackage
`default_nettype wire

FILE: design/mhu_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on mhu_pkg for the field widths.
`default_nettype none
interface mhu_sample_if;
	logic valid;
	logic ready;
	logic [mhu_pkg::BYTE_W-1:0] status_byte;
	logic [mhu_pkg::BYTE_W-1:0] x_low_byte;
	logic [mhu_pkg::BYTE_W-1:0] x_high_byte;
	logic [mhu_pkg::BYTE_W-1:0] y_low_byte;
	logic [mhu_pkg::BYTE_W-1:0] y_high_byte;
	logic [mhu_pkg::BYTE_W-1:0] z_low_byte;
	logic [mhu_pkg::BYTE_W-1:0] z_high_byte;
	modport source (output valid, status_byte, x_low_byte, x_high_byte, y_low_byte,
		y_high_byte, z_low_byte, z_high_byte, input ready);
	modport sink (input valid, status_byte, x_low_byte, x_high_byte, y_low_byte,
		y_high_byte, z_low_byte, z_high_byte, output ready);
endinterface

interface mhu_result_if;
	logic valid;
	logic ready;
	logic signed [mhu_pkg::FIELD_W-1:0] x_field;
	logic signed [mhu_pkg::FIELD_W-1:0] y_field;
	logic signed [mhu_pkg::FIELD_W-1:0] z_field;
	logic [mhu_pkg::HEADING_W-1:0] heading;
	modport source (output valid, x_field, y_field, z_field, heading, input ready);
	modport sink (input valid, x_field, y_field, z_field, heading, output ready);
endinterface
`default_nettype wire

FILE: design/mhu_front.sv
// Entry stage: assembles the counts, drops items that give no result and
// turns left half plane vectors by 90 degrees. Depends on mhu_pkg, mhu_if.
`default_nettype none
module mhu_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic online,
	mhu_sample_if.sink sample,
	output logic out_valid,
	input  wire logic out_ready,
	output mhu_pkg::cordic_vec_t out_data
);
	logic valid_q;
	mhu_pkg::cordic_vec_t data_q;
	mhu_pkg::cordic_vec_t start;
	logic signed [mhu_pkg::FIELD_W-1:0] xs, ys, zs;
	logic signed [mhu_pkg::VEC_W-1:0] xv, yv;
	logic take, pass;

	assign sample.ready = !valid_q || out_ready;
	assign take = sample.valid && sample.ready;
	assign pass = online && sample.status_byte[mhu_pkg::DRDY_BIT];

	// Little-endian words, then scaled into the vector format.
	assign xs = {sample.x_high_byte, sample.x_low_byte};
	assign ys = {sample.y_high_byte, sample.y_low_byte};
	assign zs = {sample.z_high_byte, sample.z_low_byte};
	assign xv = mhu_pkg::VEC_W'(xs) <<< mhu_pkg::INPUT_SHIFT;
	assign yv = mhu_pkg::VEC_W'(ys) <<< mhu_pkg::INPUT_SHIFT;

	// Vectors with negative x are turned into the right half plane first.
	always_comb begin
		start.x = xv;
		start.y = yv;
		start.z = '0;
		if (xv < 0) begin
			if (yv >= 0) begin
				start.x = yv;
				start.y = -xv;
				start.z = mhu_pkg::ANG_90;
			end else begin
				start.x = -yv;
				start.y = xv;
				start.z = -mhu_pkg::ANG_90;
			end
		end
		start.zero_vec = (xs == '0) && (ys == '0);
		start.x_field = xs;
		start.y_field = ys;
		start.z_field = zs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= pass;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= start;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;
endmodule
`default_nettype wire

FILE: design/mhu_cordic_cell.sv
// One vectoring CORDIC rotation with its own item register.
// Depends on mhu_pkg for the vector type and the arctangent table.
`default_nettype none
module mhu_cordic_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [mhu_pkg::STEP_IDX_W-1:0] step_idx,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire mhu_pkg::cordic_vec_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output mhu_pkg::cordic_vec_t out_data
);
	logic valid_q;
	mhu_pkg::cordic_vec_t data_q;
	mhu_pkg::cordic_vec_t nxt;
	logic signed [mhu_pkg::VEC_W-1:0] dx, dy;
	logic signed [mhu_pkg::ANG_W-1:0] atan_v;

	assign in_ready = !valid_q || out_ready;

	// Arithmetic shift rounds toward minus infinity, as the rotation needs.
	assign dx = in_data.y >>> step_idx;
	assign dy = in_data.x >>> step_idx;
	assign atan_v = mhu_pkg::atan_of(step_idx);

	// Rotate toward the x axis and accumulate the angle turned.
	always_comb begin
		nxt = in_data;
		if (in_data.y > 0) begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + atan_v;
		end else begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - atan_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;
endmodule
`default_nettype wire

FILE: design/mhu_back.sv
// Exit stages: folds the angle into [0, 360), rounds it to heading units
// and holds the result item. Depends on mhu_pkg and mhu_if.
`default_nettype none
module mhu_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire mhu_pkg::cordic_vec_t in_data,
	mhu_result_if.source result
);
	logic valid_s1, valid_q, ready_q;
	mhu_pkg::cordic_vec_t data_s1;
	logic signed [mhu_pkg::ANG_W-1:0] z_fold, z_fold_s1, z_rnd, z_wrap;
	logic [mhu_pkg::HEADING_W-1:0] heading_q;
	logic signed [mhu_pkg::FIELD_W-1:0] x_q, y_q, zf_q;

	assign ready_q = !valid_q || result.ready;
	assign in_ready = !valid_s1 || ready_q;

	// Negative angles get a full turn added.
	always_comb begin
		z_fold = (in_data.z < 0) ? in_data.z + mhu_pkg::ANG_360 : in_data.z;
		if (z_fold < 0) begin
			z_fold = '0;
		end
	end

	// Round half up into heading units; a full turn wraps to zero.
	assign z_rnd = (z_fold_s1 + mhu_pkg::ROUND_HALF) >>> mhu_pkg::ROUND_SH;
	assign z_wrap = (z_rnd >= mhu_pkg::HEADING_FULL_A) ? z_rnd - mhu_pkg::HEADING_FULL_A : z_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_q) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
			z_fold_s1 <= z_fold;
		end
		if (ready_q && valid_s1) begin
			heading_q <= data_s1.zero_vec ? '0 : z_wrap[mhu_pkg::HEADING_W-1:0];
			x_q <= data_s1.x_field;
			y_q <= data_s1.y_field;
			zf_q <= data_s1.z_field;
		end
	end

	assign result.valid = valid_q;
	assign result.x_field = x_q;
	assign result.y_field = y_q;
	assign result.z_field = zf_q;
	assign result.heading = heading_q;
endmodule
`default_nettype wire

FILE: design/magnetometer_heading_unit.sv
// Magnetometer heading unit: field counts and atan2 compass heading per item.
// Path: an accepted item passes the entry stage, one register per CORDIC
// rotation cell, the fold stage and the output register to its result.
// Throughput: one item per cycle unless stalled; every cell holds one item.
// Reset: arst_n clears all valid flags and the sensor_online register.
`default_nettype none
module magnetometer_heading_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	mhu_sample_if.sink sample,
	mhu_result_if.source result
);
	`include "magnetometer_heading_unit_assert.svh"

	logic online_q;
	logic chain_valid [mhu_pkg::NUM_CELLS+1];
	logic chain_ready [mhu_pkg::NUM_CELLS+1];
	mhu_pkg::cordic_vec_t chain_data [mhu_pkg::NUM_CELLS+1];

	// Sensor online register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q <= 1'b0;
		end else if (cfg_we) begin
			online_q <= cfg_wdata;
		end
	end

	mhu_front u_front (
		.clk(clk), .arst_n(arst_n), .online(online_q), .sample(sample),
		.out_valid(chain_valid[0]), .out_ready(chain_ready[0]), .out_data(chain_data[0])
	);

	// Row of rotation cells, one per CORDIC step.
	for (genvar g = 0; g < mhu_pkg::NUM_CELLS; g++) begin : g_cell
		mhu_cordic_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step_idx(mhu_pkg::STEP_IDX_W'(g)),
			.in_valid(chain_valid[g]), .in_ready(chain_ready[g]), .in_data(chain_data[g]),
			.out_valid(chain_valid[g+1]), .out_ready(chain_ready[g+1]),
			.out_data(chain_data[g+1])
		);
	end

	mhu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(chain_valid[mhu_pkg::NUM_CELLS]), .in_ready(chain_ready[mhu_pkg::NUM_CELLS]),
		.in_data(chain_data[mhu_pkg::NUM_CELLS]), .result(result)
	);

	// An item taken while the sensor is offline never enters the chain.
	`MHU_CHECK_NEXT(a_offline_drop, sample.valid && sample.ready && !online_q, !chain_valid[0], "offline item entered chain")
	// A zero vector always reports a heading of zero.
	`MHU_CHECK(a_zero_heading, !result.valid || result.x_field != 0 || result.y_field != 0 || result.heading == 0, "zero vector heading not zero")
	// The heading stays below a full turn whenever it fits the field.
	`MHU_CHECK(a_heading_range, !result.valid || (mhu_pkg::HEADING_FULL > (1 << mhu_pkg::HEADING_W)) || (int'(result.heading) < mhu_pkg::HEADING_FULL), "heading beyond full turn")
endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for magnetometer_heading_unit: field counts and CORDIC heading.
// Depends on mhu_pkg and the channel interfaces in mhu_if.sv; the predictor is local.
module tb;
	// Fixed-point layout of the heading predictor.
	localparam int VEC_SHIFT = 24;
	localparam int ANGLE_FRAC = 20;
	localparam int ATAN_LEN = 24;
	localparam int ROT_STEPS = (mhu_pkg::CORDIC_STEPS < ATAN_LEN) ?
		mhu_pkg::CORDIC_STEPS : ATAN_LEN;
	localparam int OUT_FRAC = (mhu_pkg::HEADING_FRAC_BITS > 19) ? 19 :
		mhu_pkg::HEADING_FRAC_BITS;
	localparam int ROUND_SHIFT = ANGLE_FRAC - OUT_FRAC;
	localparam longint ANG_QUARTER = longint'(90) <<< ANGLE_FRAC;
	localparam longint ANG_FULL_TURN = longint'(360) <<< ANGLE_FRAC;
	localparam longint HEADING_TURN = longint'(360) <<< OUT_FRAC;

	// atan(2^-i) in degrees, scaled by 2^20 and rounded to nearest.
	localparam longint ATAN_DEG [ATAN_LEN] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	localparam bit SENSOR_OFFLINE = 1'b0;
	localparam bit SENSOR_ONLINE = 1'b1;
	localparam logic [mhu_pkg::BYTE_W-1:0] STATUS_READY = 8'h01;
	localparam logic [mhu_pkg::BYTE_W-1:0] STATUS_IDLE = 8'h00;

	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [mhu_pkg::BYTE_W-1:0] status_byte;
		logic [mhu_pkg::BYTE_W-1:0] x_low_byte;
		logic [mhu_pkg::BYTE_W-1:0] x_high_byte;
		logic [mhu_pkg::BYTE_W-1:0] y_low_byte;
		logic [mhu_pkg::BYTE_W-1:0] y_high_byte;
		logic [mhu_pkg::BYTE_W-1:0] z_low_byte;
		logic [mhu_pkg::BYTE_W-1:0] z_high_byte;
	} sample_t;

	typedef struct {
		logic signed [mhu_pkg::FIELD_W-1:0] x_field;
		logic signed [mhu_pkg::FIELD_W-1:0] y_field;
		logic signed [mhu_pkg::FIELD_W-1:0] z_field;
		logic [mhu_pkg::HEADING_W-1:0] heading;
	} field_set_t;

	// Predicts the field sets of accepted samples and checks them in order.
	class heading_scoreboard;
		field_set_t pending[$];
		bit online;
		int unsigned error_count;

		function new();
			online = SENSOR_OFFLINE;
			error_count = 0;
		endfunction

		// Vectoring CORDIC on the counts; the angle ends up in output units.
		function logic [mhu_pkg::HEADING_W-1:0] heading_of_counts(int xs, int ys);
			longint vx, vy, ang, tmp, dx, dy;
			if (xs == 0 && ys == 0)
				return '0;
			vx = longint'(xs) <<< VEC_SHIFT;
			vy = longint'(ys) <<< VEC_SHIFT;
			ang = 0;
			// Vectors in the left half plane are turned by a quarter first.
			if (vx < 0) begin
				tmp = vx;
				if (vy >= 0) begin
					vx = vy;
					vy = -tmp;
					ang = ANG_QUARTER;
				end else begin
					vx = -vy;
					vy = tmp;
					ang = -ANG_QUARTER;
				end
			end
			for (int i = 0; i < ROT_STEPS; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy > 0) begin
					vx += dx;
					vy -= dy;
					ang += ATAN_DEG[i];
				end else begin
					vx -= dx;
					vy += dy;
					ang -= ATAN_DEG[i];
				end
			end
			// Fold into one turn, round half up, and wrap a full turn to zero.
			if (ang < 0)
				ang += ANG_FULL_TURN;
			if (ang < 0)
				ang = 0;
			ang = (ang + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			while (ang >= HEADING_TURN)
				ang -= HEADING_TURN;
			return ang[mhu_pkg::HEADING_W-1:0];
		endfunction

		function void note_sample(sample_t s);
			field_set_t f;
			if (!online || !s.status_byte[mhu_pkg::DRDY_BIT])
				return;
			f.x_field = {s.x_high_byte, s.x_low_byte};
			f.y_field = {s.y_high_byte, s.y_low_byte};
			f.z_field = {s.z_high_byte, s.z_low_byte};
			f.heading = heading_of_counts(int'(f.x_field), int'(f.y_field));
			pending.push_back(f);
		endfunction

		function void report(string field, int want, int got);
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field,
					want, got);
		endfunction

		function void check_result(field_set_t got);
			field_set_t want;
			if (pending.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result with nothing expected: x %0d y %0d z %0d heading %0d",
						$realtime, got.x_field, got.y_field, got.z_field, got.heading);
				return;
			end
			want = pending.pop_front();
			if (got.x_field !== want.x_field)
				report("x_field", want.x_field, got.x_field);
			if (got.y_field !== want.y_field)
				report("y_field", want.y_field, got.y_field);
			if (got.z_field !== want.z_field)
				report("z_field", want.z_field, got.z_field);
			if (got.heading !== want.heading)
				report("heading", want.heading, got.heading);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int unsigned src_gap_max;
	int unsigned snk_stall_max;
	int unsigned cycle_count;
	heading_scoreboard sb;

	mhu_sample_if sample_ch();
	mhu_result_if result_ch();

	magnetometer_heading_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample(sample_ch),
		.result(result_ch)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Field count with extra weight on the extremes, small values and zero.
	function automatic logic [mhu_pkg::FIELD_W-1:0] random_count();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					3: return 16'h0001;
					default: return 16'h0000;
				endcase
			end
			1, 2: return 16'($urandom_range(0, 16) - 8);
			3: return '0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		logic [mhu_pkg::FIELD_W-1:0] x, y, z;
		x = random_count();
		y = random_count();
		z = random_count();
		s.status_byte = 8'($urandom);
		s.status_byte[mhu_pkg::DRDY_BIT] = ($urandom_range(0, 99) < 85);
		{s.x_high_byte, s.x_low_byte} = x;
		{s.y_high_byte, s.y_low_byte} = y;
		{s.z_high_byte, s.z_low_byte} = z;
		return s;
	endfunction

	// Offers one item after a random gap and returns at the edge that accepts it.
	task automatic push_sample(sample_t s);
		int unsigned gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.status_byte <= s.status_byte;
		sample_ch.x_low_byte <= s.x_low_byte;
		sample_ch.x_high_byte <= s.x_high_byte;
		sample_ch.y_low_byte <= s.y_low_byte;
		sample_ch.y_high_byte <= s.y_high_byte;
		sample_ch.z_low_byte <= s.z_low_byte;
		sample_ch.z_high_byte <= s.z_high_byte;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		sb.note_sample(s);
	endtask

	task automatic push_counts(logic [mhu_pkg::BYTE_W-1:0] status,
			logic [mhu_pkg::FIELD_W-1:0] x, logic [mhu_pkg::FIELD_W-1:0] y,
			logic [mhu_pkg::FIELD_W-1:0] z);
		sample_t s;
		s.status_byte = status;
		{s.x_high_byte, s.x_low_byte} = x;
		{s.y_high_byte, s.y_low_byte} = y;
		{s.z_high_byte, s.z_low_byte} = z;
		push_sample(s);
	endtask

	// Stops the sender and waits until the pipeline holds nothing.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_online(bit value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.online = value;
	endtask

	// Random items; the pacing of both sides changes every 64 items.
	task automatic run_random(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0) begin
				src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
				snk_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
			end
			push_sample(random_sample());
		end
	endtask

	// Result side: random stalls, then check each item it takes.
	initial begin : result_sink
		field_set_t got;
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, snk_stall_max);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.x_field = result_ch.x_field;
			got.y_field = result_ch.y_field;
			got.z_field = result_ch.z_field;
			got.heading = result_ch.heading;
			sb.check_result(got);
		end
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		sb = new();
		src_gap_max = 3;
		snk_stall_max = 3;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		result_ch.ready <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.status_byte <= '0;
		sample_ch.x_low_byte <= '0;
		sample_ch.x_high_byte <= '0;
		sample_ch.y_low_byte <= '0;
		sample_ch.y_high_byte <= '0;
		sample_ch.z_low_byte <= '0;
		sample_ch.z_high_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the sensor is offline, so ready samples give nothing.
		push_counts(8'hFF, 16'h1234, 16'h8000, 16'h7FFF);
		push_counts(STATUS_READY, 16'h0001, 16'h0001, 16'h0000);
		run_random(4);
		settle();
		set_online(SENSOR_ONLINE);

		// Directed: axes, quadrants, extremes, the fold wrap and the ready bit.
		push_counts(STATUS_READY, 16'h0000, 16'h0000, 16'h0000);
		push_counts(STATUS_READY, 16'h0001, 16'h0000, 16'h7FFF);
		push_counts(STATUS_READY, 16'h0000, 16'h0001, 16'h8000);
		push_counts(STATUS_READY, 16'hFFFF, 16'h0000, 16'h0001);
		push_counts(STATUS_READY, 16'h0000, 16'hFFFF, 16'hFFFF);
		push_counts(STATUS_READY, 16'hFFFF, 16'hFFFF, 16'h0000);
		push_counts(STATUS_READY, 16'h0001, 16'hFFFF, 16'h0000);
		push_counts(STATUS_READY, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_counts(STATUS_READY, 16'h8000, 16'h8000, 16'h8000);
		push_counts(STATUS_READY, 16'h8000, 16'h7FFF, 16'h0000);
		push_counts(STATUS_READY, 16'h7FFF, 16'h8000, 16'h0000);
		push_counts(STATUS_READY, 16'h8000, 16'h0000, 16'h0000);
		push_counts(STATUS_READY, 16'h8000, 16'h0001, 16'h0000);
		push_counts(STATUS_READY, 16'h8000, 16'hFFFF, 16'h0000);
		push_counts(STATUS_READY, 16'h7FFF, 16'hFFFF, 16'h0000);
		push_counts(STATUS_READY, 16'h0000, 16'h8000, 16'h0000);
		push_counts(STATUS_IDLE, 16'h1234, 16'h5678, 16'h9ABC);
		push_counts(8'hFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_counts(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_counts(STATUS_READY, 16'h5555, 16'hAAAA, 16'h00FF);
		// The sender holds off here until every result is back.
		settle();

		run_random(900);
		settle();
		set_online(SENSOR_OFFLINE);
		run_random(60);
		settle();
		set_online(SENSOR_ONLINE);
		run_random(1000);
		settle();

		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
